// ----- sv/quad_cell_spot_position_core_assert.svh -----
// Assertion macros for the quad cell spot position core.
// Depends on nothing; included by quad_cell_spot_position_core.sv, the file that carries assertions.
`ifndef QUAD_CELL_SPOT_POSITION_CORE_ASSERT_SVH
`define QUAD_CELL_SPOT_POSITION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define QCSP_ASSERT_IMPL(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("qcsp assertion failed");
`define QCSP_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("qcsp assertion failed");
`else
`define QCSP_ASSERT_IMPL(label, clock, resetn, ante, cons)
`define QCSP_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif
`endif

// ----- sv/qcsp_pkg.sv -----
// Types and constants shared by the quad cell spot position core.
// Depends on nothing.
`timescale 1ns / 1ps
package qcsp_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IN_W            = 16;
    localparam int POS_W           = 32;
    localparam int CFG_W           = 32;
    localparam int ADDR_W          = 3;
    localparam int Q_W             = 31;

    localparam logic [29:0]        EDGE_Q30   = 30'd1073740750;
    localparam logic signed [32:0] K_Q28      = 33'sd1162525979;
    localparam logic [29:0]        LN2_Q30    = 30'd744261118;
    localparam logic [29:0]        RSQRT2_Q30 = 30'd759250125;
    localparam logic [34:0]        RECIP_147  = 35'd29217464598;
    localparam logic [51:0]        LIM_POS    = 52'd2147483647;
    localparam logic [51:0]        LIM_NEG    = 52'd2147483648;
    localparam logic [31:0]        POS_TOP    = 32'h7fffffff;
    localparam logic [31:0]        NEG_TOP    = 32'h80000000;

    typedef enum logic {
        REG_BEAM_WIDTH     = 1'b0,
        REG_POSITION_SCALE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [IN_W-1:0] intensity_a;
        logic [IN_W-1:0] intensity_b;
        logic [IN_W-1:0] intensity_c;
        logic [IN_W-1:0] intensity_d;
    } in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    zero_sum;
        logic                    saturated;
    } out_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } side_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             sat;
        logic [POS_W-1:0] pos;
    } axis_out_t;

endpackage

// ----- sv/qcsp_axis.sv -----
// One axis pipeline: divide, inverse error function shape, scale, saturate.
// Depends on qcsp_pkg.
`timescale 1ns / 1ps
module qcsp_axis #(
    parameter int SUM_W = qcsp_pkg::SAMPLE_BITS_DEF + 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qcsp_pkg::side_t          side_in,
    input  logic [SUM_W-1:0]         mag,
    input  logic [SUM_W-1:0]         sum,
    input  logic [qcsp_pkg::CFG_W-1:0] beam_width,
    input  logic [qcsp_pkg::CFG_W-1:0] position_scale,
    output qcsp_pkg::axis_out_t      axis_out
);

    localparam int RW     = SUM_W + 1;
    localparam int QW     = qcsp_pkg::Q_W;
    localparam int DIV_N  = QW;
    localparam int NRM_N  = 3;
    localparam int LOG_N  = 30;
    localparam int SQRT_N = 32;
    localparam int LAT    = DIV_N + 1 + NRM_N + LOG_N + 7 + SQRT_N + 1 + SQRT_N + 4;

    qcsp_pkg::side_t side_reg [0:LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // restoring divide, one quotient bit per stage
    logic [SUM_W-1:0] div_rem_reg [0:DIV_N-1];
    logic [SUM_W-1:0] div_sum_reg [0:DIV_N-1];
    logic [QW-1:0]    div_q_reg   [0:DIV_N-1];

    for (genvar k = 0; k < DIV_N; k++)
    begin : g_div
        logic [RW-1:0]    part;
        logic [SUM_W-1:0] sum_src;
        logic [QW-1:0]    q_src;
        logic             ge;
        logic [SUM_W-1:0] rem_next;
        logic [QW-1:0]    q_next;

        if (k == 0)
        begin : g_first
            assign part    = {1'b0, mag};
            assign sum_src = sum;
            assign q_src   = '0;
        end
        else
        begin : g_rest
            assign part    = {div_rem_reg[k-1], 1'b0};
            assign sum_src = div_sum_reg[k-1];
            assign q_src   = div_q_reg[k-1];
        end

        assign ge       = part >= {1'b0, sum_src};
        assign rem_next = ge ? SUM_W'(part - {1'b0, sum_src}) : SUM_W'(part);
        assign q_next   = ge ? (q_src | (QW'(1) << (DIV_N - 1 - k))) : q_src;

        always_ff @(posedge clk)
        begin
            div_rem_reg[k] <= rem_next;
            div_sum_reg[k] <= sum_src;
            div_q_reg[k]   <= q_next;
        end
    end

    // clamp and square
    logic [29:0] ec;
    logic [59:0] sq_next;
    logic [59:0] sq_reg;

    assign ec      = (div_q_reg[DIV_N-1] > QW'(qcsp_pkg::EDGE_Q30))
                     ? qcsp_pkg::EDGE_Q30 : div_q_reg[DIV_N-1][29:0];
    assign sq_next = 60'(ec) * 60'(ec);

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    // normalize u = 1 - e^2 to a leading one
    logic [60:0] u_val;
    logic [63:0] nrm_w_reg  [0:NRM_N-1];
    logic [5:0]  nrm_sh_reg [0:NRM_N-1];

    assign u_val = (61'(1) << 60) - 61'(sq_reg);

    for (genvar j = 0; j < NRM_N; j++)
    begin : g_nrm
        localparam int SHA = 1 << (5 - 2 * j);
        localparam int SHB = 1 << (4 - 2 * j);
        logic [63:0] w_src;
        logic [63:0] w_a;
        logic [63:0] w_next;
        logic [5:0]  sh_src;
        logic [5:0]  sh_a;
        logic [5:0]  sh_next;

        if (j == 0)
        begin : g_first
            assign w_src  = {3'b000, u_val};
            assign sh_src = '0;
        end
        else
        begin : g_rest
            assign w_src  = nrm_w_reg[j-1];
            assign sh_src = nrm_sh_reg[j-1];
        end

        always_comb
        begin
            w_a  = w_src;
            sh_a = sh_src;
            if (w_src[63 -: SHA] == '0)
            begin
                w_a  = w_src << SHA;
                sh_a = sh_src | 6'(SHA);
            end
            w_next  = w_a;
            sh_next = sh_a;
            if (w_a[63 -: SHB] == '0)
            begin
                w_next  = w_a << SHB;
                sh_next = sh_a | 6'(SHB);
            end
        end

        always_ff @(posedge clk)
        begin
            nrm_w_reg[j]  <= w_next;
            nrm_sh_reg[j] <= sh_next;
        end
    end

    // fraction of log2 by repeated squaring
    logic [30:0] log_m_reg  [0:LOG_N-1];
    logic [29:0] log_f_reg  [0:LOG_N-1];
    logic [4:0]  log_ip_reg [0:LOG_N-1];

    for (genvar k = 0; k < LOG_N; k++)
    begin : g_log
        logic [30:0] m_src;
        logic [29:0] f_src;
        logic [4:0]  ip_src;
        logic [61:0] mm;
        logic [31:0] tq;
        logic [30:0] m_next;
        logic [29:0] f_next;

        if (k == 0)
        begin : g_first
            assign m_src  = nrm_w_reg[NRM_N-1][63:33];
            assign f_src  = '0;
            assign ip_src = 5'(nrm_sh_reg[NRM_N-1] - 6'd3);
        end
        else
        begin : g_rest
            assign m_src  = log_m_reg[k-1];
            assign f_src  = log_f_reg[k-1];
            assign ip_src = log_ip_reg[k-1];
        end

        assign mm     = 62'(m_src) * 62'(m_src);
        assign tq     = mm[61:30];
        assign m_next = tq[31] ? tq[31:1] : tq[30:0];
        assign f_next = {f_src[28:0], tq[31]};

        always_ff @(posedge clk)
        begin
            log_m_reg[k]  <= m_next;
            log_f_reg[k]  <= f_next;
            log_ip_reg[k] <= ip_src;
        end
    end

    // natural log, L / 0.147, t and t^2
    logic [34:0]        l2_next;
    logic [34:0]        l2_reg;
    logic [64:0]        lprod;
    logic [31:0]        l_reg;
    logic [66:0]        qprod;
    logic [34:0]        q0_reg;
    logic [31:0]        l1_reg;
    logic [42:0]        lk;
    logic [42:0]        qk;
    logic [42:0]        lrem;
    logic [34:0]        la_next;
    logic [34:0]        la_reg;
    logic [31:0]        l2c_reg;
    logic signed [32:0] t_next;
    logic [30:0]        tmag_next;
    logic signed [32:0] t_reg;
    logic [30:0]        tmag_reg;
    logic [34:0]        la1_reg;
    logic [61:0]        ttprod;
    logic [33:0]        tt_reg;
    logic signed [32:0] t1_reg;
    logic [34:0]        la2_reg;
    logic [35:0]        r_reg;
    logic signed [32:0] t2_reg;

    assign l2_next   = {log_ip_reg[LOG_N-1], 30'b0} - 35'(log_f_reg[LOG_N-1]);
    assign lprod     = 65'(l2_reg) * 65'(qcsp_pkg::LN2_Q30);
    assign qprod     = 67'(l_reg) * 67'(qcsp_pkg::RECIP_147);
    assign lk        = 43'(l1_reg) * 43'(1000);
    assign qk        = 43'(q0_reg) * 43'(147);
    assign lrem      = lk - qk;
    assign la_next   = (lrem >= 43'(147)) ? q0_reg + 35'(1) : q0_reg;
    assign t_next    = qcsp_pkg::K_Q28 - $signed({2'b00, l2c_reg[31:1]});
    assign tmag_next = t_next[32] ? 31'(-t_next) : 31'(t_next);
    assign ttprod    = 62'(tmag_reg) * 62'(tmag_reg);

    always_ff @(posedge clk)
    begin
        l2_reg   <= l2_next;
        l_reg    <= lprod[63:32];
        q0_reg   <= qprod[66:32];
        l1_reg   <= l_reg;
        la_reg   <= la_next;
        l2c_reg  <= l1_reg;
        t_reg    <= t_next;
        tmag_reg <= tmag_next;
        la1_reg  <= la_reg;
        tt_reg   <= ttprod[61:28];
        t1_reg   <= t_reg;
        la2_reg  <= la1_reg;
        r_reg    <= 36'(tt_reg) + 36'(la2_reg);
        t2_reg   <= t1_reg;
    end

    // s = isqrt(r << 28), one result bit per stage
    logic [63:0]        s_x_reg   [0:SQRT_N-1];
    logic [63:0]        s_res_reg [0:SQRT_N-1];
    logic signed [32:0] s_t_reg   [0:SQRT_N-1];

    for (genvar i = 0; i < SQRT_N; i++)
    begin : g_sqs
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
        logic [63:0]        x_src;
        logic [63:0]        res_src;
        logic signed [32:0] t_src;
        logic [63:0]        cand;
        logic [63:0]        x_next;
        logic [63:0]        res_next;

        if (i == 0)
        begin : g_first
            assign x_src   = {r_reg, 28'b0};
            assign res_src = '0;
            assign t_src   = t2_reg;
        end
        else
        begin : g_rest
            assign x_src   = s_x_reg[i-1];
            assign res_src = s_res_reg[i-1];
            assign t_src   = s_t_reg[i-1];
        end

        assign cand     = res_src + BIT;
        assign x_next   = (x_src >= cand) ? x_src - cand : x_src;
        assign res_next = (x_src >= cand) ? (res_src >> 1) + BIT : res_src >> 1;

        always_ff @(posedge clk)
        begin
            s_x_reg[i]   <= x_next;
            s_res_reg[i] <= res_next;
            s_t_reg[i]   <= t_src;
        end
    end

    // d = max(s - t, 0)
    logic signed [33:0] d_full;
    logic [32:0]        d_reg;

    assign d_full = $signed({2'b00, s_res_reg[SQRT_N-1][31:0]}) - 34'(s_t_reg[SQRT_N-1]);

    always_ff @(posedge clk)
    begin
        d_reg <= d_full[33] ? '0 : d_full[32:0];
    end

    // v = isqrt(d << 28)
    logic [63:0] v_x_reg   [0:SQRT_N-1];
    logic [63:0] v_res_reg [0:SQRT_N-1];

    for (genvar i = 0; i < SQRT_N; i++)
    begin : g_sqv
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
        logic [63:0] x_src;
        logic [63:0] res_src;
        logic [63:0] cand;
        logic [63:0] x_next;
        logic [63:0] res_next;

        if (i == 0)
        begin : g_first
            assign x_src   = {3'b000, d_reg, 28'b0};
            assign res_src = '0;
        end
        else
        begin : g_rest
            assign x_src   = v_x_reg[i-1];
            assign res_src = v_res_reg[i-1];
        end

        assign cand     = res_src + BIT;
        assign x_next   = (x_src >= cand) ? x_src - cand : x_src;
        assign res_next = (x_src >= cand) ? (res_src >> 1) + BIT : res_src >> 1;

        always_ff @(posedge clk)
        begin
            v_x_reg[i]   <= x_next;
            v_res_reg[i] <= res_next;
        end
    end

    // scale by 1/sqrt2, beam width and position scale; saturate
    logic [60:0] gprod;
    logic [30:0] g_reg;
    logic [62:0] p1prod;
    logic [34:0] p1_reg;
    logic [50:0] ph_next;
    logic [50:0] pl_full;
    logic [50:0] ph_reg;
    logic [34:0] pl_reg;
    logic [51:0] p_sum;
    logic [51:0] lim;
    logic        sat_raw;
    logic [31:0] p_clip;
    logic [31:0] pos_next;
    logic        sat_next;
    logic [31:0] pos_reg;
    logic        sat_reg;
    qcsp_pkg::side_t side_last;

    assign gprod     = 61'(v_res_reg[SQRT_N-1][30:0]) * 61'(qcsp_pkg::RSQRT2_Q30);
    assign p1prod    = 63'(g_reg) * 63'(beam_width);
    assign ph_next   = 51'(p1_reg) * 51'(position_scale[31:16]);
    assign pl_full   = 51'(p1_reg) * 51'(position_scale[15:0]);
    assign side_last = side_reg[LAT-2];
    assign p_sum     = 52'(ph_reg) + 52'(pl_reg);
    assign lim       = side_last.neg ? qcsp_pkg::LIM_NEG : qcsp_pkg::LIM_POS;
    assign sat_raw   = p_sum > lim;
    assign p_clip    = sat_raw ? lim[31:0] : p_sum[31:0];

    always_comb
    begin
        pos_next = side_last.neg ? (32'd0 - p_clip) : p_clip;
        sat_next = sat_raw;
        if (side_last.zero)
        begin
            pos_next = '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg   <= gprod[60:30];
        p1_reg  <= p1prod[62:28];
        ph_reg  <= ph_next;
        pl_reg  <= pl_full[50:16];
        pos_reg <= pos_next;
        sat_reg <= sat_next;
    end

    assign axis_out.valid = side_reg[LAT-1].valid;
    assign axis_out.zero  = side_reg[LAT-1].zero;
    assign axis_out.sat   = sat_reg;
    assign axis_out.pos   = pos_reg;

endmodule

// ----- sv/quad_cell_spot_position_core.sv -----
// Top level of the quad cell spot position core: ports, registers, two axis pipelines.
// Depends on qcsp_pkg, qcsp_axis and quad_cell_spot_position_core_assert.svh.
//
//   channel  | signals                                 | handshake
//   ---------+-----------------------------------------+-------------------------------
//   sample   | start, busy, sample                     | beat on start while busy low
//   result   | done, result                            | one result per beat, no stall
//   config   | psel, penable, pwrite, paddr, pwdata,   | APB write on access cycle,
//            | prdata, pready                          | pready tied high
//
// One beat is taken every cycle; busy stays low.
// A result passes through one input register plus 141 pipeline stages, set by the
// 31-stage divider, the 30-stage log2 squaring chain and two 32-stage square roots.
// Reset clears the valid bits and sets both scale registers to 1.0.
`timescale 1ns / 1ps
`include "quad_cell_spot_position_core_assert.svh"
module quad_cell_spot_position_core #(
    parameter int SAMPLE_BITS = qcsp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  qcsp_pkg::in_t               sample,
    output logic                        done,
    output qcsp_pkg::out_t              result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qcsp_pkg::ADDR_W-1:0] paddr,
    input  logic [qcsp_pkg::CFG_W-1:0]  pwdata,
    output logic [qcsp_pkg::CFG_W-1:0]  prdata,
    output logic                        pready
);

    localparam int EW    = (SAMPLE_BITS < qcsp_pkg::IN_W) ? SAMPLE_BITS : qcsp_pkg::IN_W;
    localparam int SUM_W = EW + 2;

    logic [qcsp_pkg::CFG_W-1:0] beam_width_reg;
    logic [qcsp_pkg::CFG_W-1:0] position_scale_reg;
    qcsp_pkg::reg_idx_t         widx;
    logic                       wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign widx   = qcsp_pkg::reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_width_reg     <= 32'd65536;
            position_scale_reg <= 32'd65536;
        end
        else if (wr_en)
        begin
            unique case (widx)
                qcsp_pkg::REG_BEAM_WIDTH:     beam_width_reg     <= pwdata;
                qcsp_pkg::REG_POSITION_SCALE: position_scale_reg <= pwdata;
                default:                      beam_width_reg     <= beam_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            qcsp_pkg::REG_BEAM_WIDTH:     prdata = beam_width_reg;
            qcsp_pkg::REG_POSITION_SCALE: prdata = position_scale_reg;
            default:                      prdata = '0;
        endcase
    end

    // input register
    logic          in_valid_reg;
    qcsp_pkg::in_t in_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= sample;
    end

    // sums and difference magnitudes
    logic [EW-1:0]    a_val;
    logic [EW-1:0]    b_val;
    logic [EW-1:0]    c_val;
    logic [EW-1:0]    d_val;
    logic [EW:0]      ad_sum;
    logic [EW:0]      bc_sum;
    logic [EW:0]      ab_sum;
    logic [EW:0]      cd_sum;
    logic [SUM_W-1:0] tot_sum;
    logic             neg_x;
    logic             neg_y;
    logic [SUM_W-1:0] mag_x;
    logic [SUM_W-1:0] mag_y;
    logic             zero;
    qcsp_pkg::side_t  side_x;
    qcsp_pkg::side_t  side_y;

    assign a_val   = in_data_reg.intensity_a[EW-1:0];
    assign b_val   = in_data_reg.intensity_b[EW-1:0];
    assign c_val   = in_data_reg.intensity_c[EW-1:0];
    assign d_val   = in_data_reg.intensity_d[EW-1:0];
    assign ad_sum  = (EW+1)'(a_val) + (EW+1)'(d_val);
    assign bc_sum  = (EW+1)'(b_val) + (EW+1)'(c_val);
    assign ab_sum  = (EW+1)'(a_val) + (EW+1)'(b_val);
    assign cd_sum  = (EW+1)'(c_val) + (EW+1)'(d_val);
    assign tot_sum = SUM_W'(ad_sum) + SUM_W'(bc_sum);
    assign neg_x   = ad_sum < bc_sum;
    assign neg_y   = ab_sum < cd_sum;
    assign mag_x   = neg_x ? SUM_W'(bc_sum - ad_sum) : SUM_W'(ad_sum - bc_sum);
    assign mag_y   = neg_y ? SUM_W'(cd_sum - ab_sum) : SUM_W'(ab_sum - cd_sum);
    assign zero    = tot_sum == '0;

    assign side_x = '{valid: in_valid_reg, neg: neg_x, zero: zero};
    assign side_y = '{valid: in_valid_reg, neg: neg_y, zero: zero};

    qcsp_pkg::axis_out_t x_out;
    qcsp_pkg::axis_out_t y_out;

    qcsp_axis #(
        .SUM_W(SUM_W)
    ) u_axis_x (
        .clk           (clk),
        .rst_n         (rst_n),
        .side_in       (side_x),
        .mag           (mag_x),
        .sum           (tot_sum),
        .beam_width    (beam_width_reg),
        .position_scale(position_scale_reg),
        .axis_out      (x_out)
    );

    qcsp_axis #(
        .SUM_W(SUM_W)
    ) u_axis_y (
        .clk           (clk),
        .rst_n         (rst_n),
        .side_in       (side_y),
        .mag           (mag_y),
        .sum           (tot_sum),
        .beam_width    (beam_width_reg),
        .position_scale(position_scale_reg),
        .axis_out      (y_out)
    );

    assign done             = x_out.valid;
    assign result.pos_x     = $signed(x_out.pos);
    assign result.pos_y     = $signed(y_out.pos);
    assign result.zero_sum  = x_out.zero;
    assign result.saturated = x_out.sat | y_out.sat;

    `QCSP_ASSERT_IMPL(a_lanes_aligned, clk, rst_n, 1'b1,
        (x_out.valid == y_out.valid) && (!x_out.valid || (x_out.zero == y_out.zero)))
    `QCSP_ASSERT_IMPL(a_zero_result, clk, rst_n, done && result.zero_sum,
        (result.pos_x == 32'sd0) && (result.pos_y == 32'sd0) && !result.saturated)
    `QCSP_ASSERT_IMPL(a_sat_at_limit, clk, rst_n, done && result.saturated,
        (result.pos_x == qcsp_pkg::POS_TOP) || (result.pos_x == qcsp_pkg::NEG_TOP) ||
        (result.pos_y == qcsp_pkg::POS_TOP) || (result.pos_y == qcsp_pkg::NEG_TOP))
    `QCSP_ASSERT_NEXT(a_cfg_write, clk, rst_n, wr_en && (widx == qcsp_pkg::REG_BEAM_WIDTH),
        beam_width_reg == $past(pwdata))

endmodule
